>>> rtl/weighted_random_selector_assert.svh
// ----------------------------------------------------------------------------
// Weighted random selector assertion macros
// Property shorthands clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECTOR_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define WRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Transaction types and codes shared by the weighted random selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int SUM_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;
  localparam int PCT_SCALE = 100;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_WEIGHT = 3'd1,
    ST_BELOW     = 3'd2,
    ST_FULL      = 3'd3,
    ST_ABSENT    = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PCT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID   = 1'd1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       entry_id;
    logic [15:0]      entry_weight;
    logic             prev_valid;
    logic [7:0]       prev_id;
    logic [63:0]      random_value;
    logic [SUM_W-1:0] known_weight;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       selected_id;
    logic [SUM_W-1:0] available_sum;
  } out_t;

endpackage

>>> rtl/wrs_ram.sv
// ----------------------------------------------------------------------------
// wrs_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/weighted_random_selector.sv
// Add, remove and select each run as a sequence of states: add walks the tree once,
// remove walks it twice, and select runs a bit-serial modulo of the 64-bit random
// value plus tree walks. One transaction is in flight at a time: in_stall stays high
// until the result is taken into the output register. Reset (rst_n low, synchronous)
// clears control state, then a clearing pass over max(MAX_ENTRIES, 256) addresses
// zeroes the tree and map.
// ----------------------------------------------------------------------------
// weighted_random_selector
// Weighted entry table over a cumulative (Fenwick) tree held in RAM; add,
// remove and select transactions run on a read-modify-write sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_random_selector #(
  parameter int MAX_ENTRIES = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  wrs_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output wrs_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wrs_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  import wrs_pkg::*;

  // AW addresses a slot, CW holds a count up to MAX_ENTRIES.
  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int WB    = WEIGHT_BITS;
  localparam int CLR_N = (MAX_ENTRIES > 256) ? MAX_ENTRIES : 256;
  localparam int CLW   = $clog2(CLR_N);
  localparam logic [CW-1:0] TOP_STEP = CW'(1) << (CW - 1);

  typedef enum logic [19:0] {
    S_CLEAR = 20'h00001,
    S_IDLE  = 20'h00002,
    S_LOOK  = 20'h00004,
    S_CHK   = 20'h00008,
    S_RM1   = 20'h00010,
    S_RM2   = 20'h00020,
    S_RM3   = 20'h00040,
    S_TRD   = 20'h00080,
    S_TWR   = 20'h00100,
    S_PW    = 20'h00200,
    S_PRD   = 20'h00400,
    S_PAC   = 20'h00800,
    S_DIVI  = 20'h01000,
    S_DIV   = 20'h02000,
    S_FADJ  = 20'h04000,
    S_FRD   = 20'h08000,
    S_FCMP  = 20'h10000,
    S_SEL   = 20'h20000,
    S_SELD  = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  // What follows a tree update walk.
  typedef enum logic [1:0] {
    PH_ADD  = 2'd0,
    PH_RM_A = 2'd1,
    PH_RM_B = 2'd2
  } phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  in_t              in_r, in_nxt;
  logic [6:0]       pct_r, pct_nxt;
  logic             avoid_r, avoid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0] avail_r, avail_nxt;
  logic [AW-1:0]    s_r, s_nxt;
  logic [WB-1:0]    ws_r, ws_nxt;
  logic [WB-1:0]    wl_r, wl_nxt;
  logic [7:0]       lid_r, lid_nxt;
  logic [CW:0]      ti_r, ti_nxt;
  logic [SUM_W-1:0] delta_r, delta_nxt;
  logic             skip_r, skip_nxt;
  logic [WB-1:0]    pw_r, pw_nxt;
  logic [AW-1:0]    pre_r, pre_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] div_r, div_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [63:0]      q_r, q_nxt;
  logic [5:0]       bit_r, bit_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic [SUM_W-1:0] rr_r, rr_nxt;
  status_t          status_r, status_nxt;
  logic [7:0]       sel_r, sel_nxt;
  logic [CLW-1:0]   clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  // RAM ports
  logic             sw_we, ios_we, soi_we, tr_we;
  logic [AW-1:0]    sw_wa, ios_wa, tr_wa, sw_ra, ios_ra, tr_ra;
  logic [7:0]       soi_wa, soi_ra, ios_wd, ios_rd;
  logic [WB-1:0]    sw_wd, sw_rd;
  logic [CW-1:0]    soi_wd, soi_rd;
  logic [SUM_W-1:0] tr_wd, tr_rd;

  // Working values
  logic [WB-1:0]    w_in;
  logic [SUM_W:0]   add_sum;
  logic [30:0]      avail_scaled, total_scaled;
  logic [CW-1:0]    sid_m1, last;
  logic [CW:0]      ti_m1, nxt_pos, nxt_m1;
  logic [SUM_W:0]   div_sh;
  logic [CW-1:0]    pos_cl;

  wrs_ram #(.WIDTH(WB), .DEPTH(MAX_ENTRIES)) u_slot_weight (
    .clk, .we(sw_we), .waddr(sw_wa), .wdata(sw_wd), .raddr(sw_ra), .rdata(sw_rd)
  );
  wrs_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_id_of_slot (
    .clk, .we(ios_we), .waddr(ios_wa), .wdata(ios_wd), .raddr(ios_ra), .rdata(ios_rd)
  );
  wrs_ram #(.WIDTH(CW), .DEPTH(256)) u_slot_of_id (
    .clk, .we(soi_we), .waddr(soi_wa), .wdata(soi_wd), .raddr(soi_ra), .rdata(soi_rd)
  );
  // Tree node i (1-based) lives at address i-1.
  wrs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ENTRIES)) u_tree (
    .clk, .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign w_in         = in_r.entry_weight[WB-1:0];
  assign add_sum      = {1'b0, avail_r} + (SUM_W + 1)'(w_in);
  assign avail_scaled = 31'(avail_r) * 31'(PCT_SCALE);
  assign total_scaled = 31'(in_r.known_weight) * 31'(pct_r);
  assign sid_m1       = soi_rd - CW'(1);
  assign last         = count_r - CW'(1);
  assign ti_m1        = ti_r - (CW + 1)'(1);
  assign nxt_pos      = {1'b0, pos_r} + {1'b0, step_r};
  assign nxt_m1       = nxt_pos - (CW + 1)'(1);
  assign div_sh       = {rem_r, q_r[63]};
  assign pos_cl       = (int'(pos_r) >= MAX_ENTRIES) ? CW'(MAX_ENTRIES - 1) : pos_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    in_nxt        = in_r;
    pct_nxt       = pct_r;
    avoid_nxt     = avoid_r;
    count_nxt     = count_r;
    avail_nxt     = avail_r;
    s_nxt         = s_r;
    ws_nxt        = ws_r;
    wl_nxt        = wl_r;
    lid_nxt       = lid_r;
    ti_nxt        = ti_r;
    delta_nxt     = delta_r;
    skip_nxt      = skip_r;
    pw_nxt        = pw_r;
    pre_nxt       = pre_r;
    sum_nxt       = sum_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    rr_nxt        = rr_r;
    status_nxt    = status_r;
    sel_nxt       = sel_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    sw_we  = 1'b0;  sw_wa  = s_r;          sw_wd  = wl_r;  sw_ra  = s_r;
    ios_we = 1'b0;  ios_wa = s_r;          ios_wd = lid_r; ios_ra = last[AW-1:0];
    soi_we = 1'b0;  soi_wa = in_r.entry_id; soi_wd = '0;   soi_ra = in_r.entry_id;
    tr_we  = 1'b0;  tr_wa  = ti_m1[AW-1:0]; tr_wd = tr_rd + delta_r;
    tr_ra  = ti_m1[AW-1:0];

    // Drop the result once the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MIN_PCT) begin
        pct_nxt = cfg_wdata[6:0];
      end else if (cfg_index == CFG_AVOID) begin
        avoid_nxt = cfg_wdata[0];
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        // Zero the tree and the identity map one address a cycle.
        tr_we  = (int'(clr_r) < MAX_ENTRIES);
        tr_wa  = clr_r[AW-1:0];
        tr_wd  = '0;
        soi_we = (int'(clr_r) < 256);
        soi_wa = clr_r[7:0];
        soi_wd = '0;
        clr_nxt = clr_r + CLW'(1);
        if (clr_r == CLW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          in_nxt     = in_data;
          status_nxt = ST_OK;
          sel_nxt    = '0;
          state_nxt  = S_LOOK;
        end
      end

      S_LOOK: begin
        soi_ra = (in_r.kind == KIND_SELECT) ? in_r.prev_id : in_r.entry_id;
        priority if (in_r.kind == KIND_NONE) begin
          state_nxt = S_DONE;
        end else if (in_r.kind != KIND_SELECT) begin
          state_nxt = S_CHK;
        end else if (avail_r == '0) begin
          status_nxt = ST_NO_WEIGHT;
          state_nxt  = S_DONE;
        end else if (pct_r != '0 && avail_r < in_r.known_weight &&
                     avail_scaled < total_scaled) begin
          status_nxt = ST_BELOW;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        priority if (in_r.kind == KIND_ADD) begin
          if (soi_rd != '0 || count_r == CW'(MAX_ENTRIES) || add_sum[SUM_W]) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            // Append at the next free slot, then walk the tree.
            sw_we     = 1'b1;
            sw_wa     = count_r[AW-1:0];
            sw_wd     = w_in;
            ios_we    = 1'b1;
            ios_wa    = count_r[AW-1:0];
            ios_wd    = in_r.entry_id;
            soi_we    = 1'b1;
            soi_wd    = count_r + CW'(1);
            ti_nxt    = {1'b0, count_r} + (CW + 1)'(1);
            delta_nxt = SUM_W'(w_in);
            phase_nxt = PH_ADD;
            state_nxt = S_TRD;
          end
        end else if (in_r.kind == KIND_REMOVE) begin
          if (soi_rd == '0 || count_r == '0) begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_DONE;
          end else begin
            s_nxt     = (sid_m1 > last) ? last[AW-1:0] : sid_m1[AW-1:0];
            sw_ra     = (sid_m1 > last) ? last[AW-1:0] : sid_m1[AW-1:0];
            state_nxt = S_RM1;
          end
        end else begin
          // Skip the previous entry's interval only if it is present.
          if (avoid_r && in_r.prev_valid && soi_rd != '0 && soi_rd <= count_r) begin
            pre_nxt   = sid_m1[AW-1:0];
            sw_ra     = sid_m1[AW-1:0];
            state_nxt = S_PW;
          end else begin
            skip_nxt  = 1'b0;
            state_nxt = S_DIVI;
          end
        end
      end

      S_RM1: begin
        ws_nxt    = sw_rd;
        sw_ra     = last[AW-1:0];
        ios_ra    = last[AW-1:0];
        state_nxt = S_RM2;
      end

      S_RM2: begin
        // Move the last slot into the freed one; harmless when they match.
        wl_nxt    = sw_rd;
        lid_nxt   = ios_rd;
        sw_we     = 1'b1;
        sw_wd     = sw_rd;
        ios_we    = 1'b1;
        ios_wd    = ios_rd;
        soi_we    = 1'b1;
        soi_wa    = ios_rd;
        soi_wd    = CW'(s_r) + CW'(1);
        ti_nxt    = {1'b0, count_r};
        delta_nxt = SUM_W'(0) - SUM_W'(sw_rd);
        phase_nxt = PH_RM_A;
        state_nxt = S_TRD;
      end

      S_RM3: begin
        soi_we     = 1'b1;
        soi_wd     = '0;
        count_nxt  = last;
        avail_nxt  = avail_r - SUM_W'(ws_r);
        state_nxt  = S_DONE;
      end

      S_TRD: begin
        if (int'(ti_r) > MAX_ENTRIES) begin
          unique case (phase_r)
            PH_ADD: begin
              count_nxt = count_r + CW'(1);
              avail_nxt = add_sum[SUM_W-1:0];
              state_nxt = S_DONE;
            end
            PH_RM_A: begin
              ti_nxt    = (CW + 1)'(s_r) + (CW + 1)'(1);
              delta_nxt = SUM_W'(wl_r) - SUM_W'(ws_r);
              phase_nxt = PH_RM_B;
            end
            PH_RM_B: begin
              state_nxt = S_RM3;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else begin
          state_nxt = S_TWR;
        end
      end

      S_TWR: begin
        tr_we     = 1'b1;
        ti_nxt    = ti_r + (ti_r & (~ti_r + (CW + 1)'(1)));
        state_nxt = S_TRD;
      end

      S_PW: begin
        pw_nxt = sw_rd;
        if (SUM_W'(sw_rd) < avail_r) begin
          skip_nxt  = 1'b1;
          sum_nxt   = '0;
          state_nxt = S_PRD;
        end else begin
          skip_nxt  = 1'b0;
          state_nxt = S_DIVI;
        end
      end

      S_PRD: begin
        // Prefix sum of the slots before the skipped one.
        tr_ra = pre_r - AW'(1);
        if (pre_r == '0) begin
          state_nxt = S_DIVI;
        end else begin
          state_nxt = S_PAC;
        end
      end

      S_PAC: begin
        sum_nxt   = sum_r + tr_rd;
        pre_nxt   = pre_r & (pre_r - AW'(1));
        state_nxt = S_PRD;
      end

      S_DIVI: begin
        div_nxt   = skip_r ? (avail_r - SUM_W'(pw_r)) : avail_r;
        rem_nxt   = '0;
        q_nxt     = in_r.random_value;
        bit_nxt   = '0;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        // One restoring-division bit a cycle; only the remainder is kept.
        if (div_sh >= {1'b0, div_r}) begin
          rem_nxt = SUM_W'(div_sh - {1'b0, div_r});
        end else begin
          rem_nxt = div_sh[SUM_W-1:0];
        end
        q_nxt   = {q_r[62:0], 1'b0};
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'd63) begin
          state_nxt = S_FADJ;
        end
      end

      S_FADJ: begin
        rr_nxt    = (skip_r && rem_r >= sum_r) ? rem_r + SUM_W'(pw_r) : rem_r;
        pos_nxt   = '0;
        step_nxt  = TOP_STEP;
        state_nxt = S_FRD;
      end

      S_FRD: begin
        tr_ra = nxt_m1[AW-1:0];
        priority if (step_r == '0) begin
          state_nxt = S_SEL;
        end else if (int'(nxt_pos) > MAX_ENTRIES) begin
          step_nxt = step_r >> 1;
        end else begin
          state_nxt = S_FCMP;
        end
      end

      S_FCMP: begin
        if (tr_rd <= rr_r) begin
          pos_nxt = nxt_pos[CW-1:0];
          rr_nxt  = rr_r - tr_rd;
        end
        step_nxt  = step_r >> 1;
        state_nxt = S_FRD;
      end

      S_SEL: begin
        ios_ra    = pos_cl[AW-1:0];
        state_nxt = S_SELD;
      end

      S_SELD: begin
        sel_nxt   = ios_rd;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_nxt.status        = status_r;
          out_nxt.selected_id   = sel_r;
          out_nxt.available_sum = avail_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_ADD;
      pct_r       <= '0;
      avoid_r     <= 1'b0;
      count_r     <= '0;
      avail_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pct_r       <= pct_nxt;
      avoid_r     <= avoid_nxt;
      count_r     <= count_nxt;
      avail_r     <= avail_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r     <= in_nxt;
    s_r      <= s_nxt;
    ws_r     <= ws_nxt;
    wl_r     <= wl_nxt;
    lid_r    <= lid_nxt;
    ti_r     <= ti_nxt;
    delta_r  <= delta_nxt;
    skip_r   <= skip_nxt;
    pw_r     <= pw_nxt;
    pre_r    <= pre_nxt;
    sum_r    <= sum_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    bit_r    <= bit_nxt;
    pos_r    <= pos_nxt;
    step_r   <= step_nxt;
    rr_r     <= rr_nxt;
    status_r <= status_nxt;
    sel_r    <= sel_nxt;
    out_r    <= out_nxt;
  end

`include "weighted_random_selector_assert.svh"

  // Entry count never passes the table size.
  `WRS_ASSERT_NOW(a_count_range, 1'b1, int'(count_r) <= MAX_ENTRIES, "entry count overflow")
  // An empty table carries no weight between transactions.
  `WRS_ASSERT_NOW(a_empty_no_weight, state_r == S_IDLE && count_r == '0, avail_r == '0,
    "weight left in empty table")
  // A failed or non-select result names no entry.
  `WRS_ASSERT_NOW(a_sel_zero, out_valid_r && out_r.status != ST_OK,
    out_r.selected_id == '0, "selected_id set on failure")
  // An accepted transaction starts its lookup next cycle.
  `WRS_ASSERT_NEXT(a_accept_look, in_valid && !in_stall, state_r == S_LOOK,
    "accepted transaction did not start")

endmodule
